FILE: src/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants of the melody tone sequencer
// Beat payload structs, operation codes and the fixed arithmetic constants
// used by the core and its checker.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned DEF_MAX_NOTES = 64;
  localparam int unsigned GAP_TICKS     = 20;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CMP_W    = 6;
  localparam int unsigned PSC_W    = 16;
  localparam int unsigned LEN_W    = 7;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  localparam int unsigned CLOCK_HZ        = 45000000;
  localparam int unsigned RELOAD_PLUS_ONE = 1024;
  // floor(floor(a/b)/c) == floor(a/(b*c)), so fold the reload into the dividend
  localparam int unsigned TONE_DIVIDEND   = CLOCK_HZ / RELOAD_PLUS_ONE;
  localparam int unsigned VOLUME_SCALE    = 50;
  localparam int unsigned ADC_FULL        = 4095;
  localparam int unsigned ADC_FULL_W      = 12;
  localparam int unsigned CMP_MAX         = 50;

  // Dividend width of the bit-serial dividers: sample*50 needs 18 bits
  localparam int unsigned DIV_W = 18;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SLOT_W-1:0]   note_slot;
    logic [FREQ_W-1:0]   note_frequency;
    logic [DUR_W-1:0]    note_duration;
    logic [SAMPLE_W-1:0] adc_sample;
  } mts_in_t;

  typedef struct packed {
    logic [CMP_W-1:0]  compare_value;
    logic              compare_write;
    logic [PSC_W-1:0]  prescaler;
    logic              prescaler_write;
    logic [SLOT_W-1:0] current_index;
  } mts_out_t;

endpackage

FILE: src/melody_tone_sequencer_core.sv
// ----------------------------------------------------------------------------
// melody_tone_sequencer_core: tick-driven melody sequencer
// Holds a note table, plays it note by note on ticks with a silent gap
// between notes, and works out PWM compare and tone prescaler per note.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one output beat. Writes, start commands,
// ignored ticks and ticks that only count down or open a gap are decoded in
// S_EXEC, and their result is loaded into the output register from S_DONE.
// A tick that starts a note issues the note table read in S_EXEC, loads the
// dividers in S_READ, runs the bit-serial dividers in S_DIV (tone prescaler,
// volume scaling and the index wrap all share one 18-step sequence), forms
// the result in S_FIN and loads the output register from S_DONE. A beat holds
// the core until its result has entered the output register; a new beat is
// accepted from the cycle after that, even while the result waits there;
// a result that finds the output register still full holds the input off until
// the register drains. The length register is written only while the core is
// idle. The note table has no reset; playing a slot never written gives
// undefined frequency and duration.
// melody_length 0 behaves as 1 and values above MaxNotes behave as MaxNotes.
module melody_tone_sequencer_core #(
  parameter int unsigned MaxNotes = mts_pkg::DEF_MAX_NOTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  mts_pkg::mts_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mts_pkg::mts_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mts_pkg::LEN_W-1:0]   cfg_data_i
);

  localparam int unsigned AW     = $clog2(MaxNotes);
  localparam int unsigned LW     = $clog2(MaxNotes + 1);
  localparam int unsigned DIV_W  = mts_pkg::DIV_W;
  localparam int unsigned STEP_W = $clog2(DIV_W);
  localparam int unsigned IDX_W  = mts_pkg::SLOT_W;
  localparam int unsigned FREQ_W = mts_pkg::FREQ_W;
  localparam int unsigned DUR_W  = mts_pkg::DUR_W;
  localparam int unsigned CMP_W  = mts_pkg::CMP_W;
  localparam int unsigned PSC_W  = mts_pkg::PSC_W;
  localparam int unsigned ADC_W  = mts_pkg::ADC_FULL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DIV,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } note_t;

  // Control state
  state_e                    state_q;
  logic [AW-1:0]             play_index_q;
  logic [DUR_W-1:0]          countdown_q;
  logic                      in_gap_q;
  logic                      playing_q;
  logic [mts_pkg::LEN_W-1:0] len_q;
  logic [STEP_W-1:0]         step_q;
  logic                      out_valid_q;
  mts_pkg::mts_out_t         out_data_q;
  mts_pkg::mts_out_t         res_q;

  // Payload and datapath
  mts_pkg::mts_in_t          item_q;
  note_t                     note_mem [MaxNotes];
  note_t                     rd_q;

  logic [DIV_W-1:0]          psc_num_q;
  logic [FREQ_W-1:0]         psc_rem_q;
  logic [PSC_W-1:0]          psc_quo_q;
  logic [DIV_W-1:0]          cmp_num_q;
  logic [ADC_W-1:0]          cmp_rem_q;
  logic [CMP_W-1:0]          cmp_quo_q;
  logic [DIV_W-1:0]          mod_num_q;
  logic [LW-1:0]             mod_rem_q;

  logic                      in_acc;
  logic                      slot_ok;
  logic                      mem_we;
  logic                      note_start;
  logic                      out_load;
  logic [LW-1:0]             eff_len;
  mts_pkg::mts_out_t         exec_res;
  mts_pkg::mts_out_t         fin_res;

  logic [FREQ_W:0]           psc_trial;
  logic                      psc_ge;
  logic [FREQ_W-1:0]         psc_rem_d;
  logic [ADC_W:0]            cmp_trial;
  logic                      cmp_ge;
  logic [ADC_W-1:0]          cmp_rem_d;
  logic [LW:0]               mod_trial;
  logic                      mod_ge;
  logic [LW-1:0]             mod_rem_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  // Take a new length only between beats
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A write beyond the table is dropped
  assign slot_ok    = (32'(item_q.note_slot) < MaxNotes);
  assign mem_we     = (state_q == S_EXEC) && (item_q.op == mts_pkg::OP_WRITE) && slot_ok;
  // Countdown expired at the end of a gap: fetch the next note
  assign note_start = (state_q == S_EXEC) && (item_q.op == mts_pkg::OP_TICK) && playing_q
                      && (countdown_q == '0) && in_gap_q;
  // Move the finished result into the output register once it is free
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Clamp the programmed length into 1..MaxNotes
  always_comb begin
    if (len_q == '0) begin
      eff_len = LW'(1);
    end else if (32'(len_q) > MaxNotes) begin
      eff_len = LW'(MaxNotes);
    end else begin
      eff_len = LW'(len_q);
    end
  end

  // Result of a beat that needs no division
  always_comb begin
    exec_res               = '0;
    exec_res.current_index = IDX_W'(play_index_q);
    case (item_q.op)
      mts_pkg::OP_START: begin
        exec_res.current_index = '0;
      end
      mts_pkg::OP_TICK: begin
        // opening the gap silences the output
        exec_res.compare_write = playing_q && (countdown_q == '0) && !in_gap_q;
      end
      default: begin
      end
    endcase
  end

  // Result of a note start, formed from the divider outputs
  always_comb begin
    fin_res               = '0;
    fin_res.compare_write = 1'b1;
    fin_res.current_index = IDX_W'(mod_rem_q);
    if (rd_q.freq != '0) begin
      fin_res.compare_value   = cmp_quo_q;
      fin_res.prescaler       = (psc_quo_q == '0) ? '0 : psc_quo_q - PSC_W'(1);
      fin_res.prescaler_write = 1'b1;
    end
  end

  // Restoring division steps, one quotient bit per cycle for each divider
  always_comb begin
    psc_trial = {psc_rem_q, psc_num_q[DIV_W-1]};
    psc_ge    = (psc_trial >= {1'b0, rd_q.freq});
    psc_rem_d = psc_ge ? FREQ_W'(psc_trial - {1'b0, rd_q.freq}) : FREQ_W'(psc_trial);

    cmp_trial = {cmp_rem_q, cmp_num_q[DIV_W-1]};
    cmp_ge    = (cmp_trial >= (ADC_W + 1)'(mts_pkg::ADC_FULL));
    cmp_rem_d = cmp_ge ? ADC_W'(cmp_trial - (ADC_W + 1)'(mts_pkg::ADC_FULL))
                       : ADC_W'(cmp_trial);

    mod_trial = {mod_rem_q, mod_num_q[DIV_W-1]};
    mod_ge    = (mod_trial >= {1'b0, eff_len});
    mod_rem_d = mod_ge ? LW'(mod_trial - {1'b0, eff_len}) : LW'(mod_trial);
  end

  // Note table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      note_mem[AW'(item_q.note_slot)] <= '{freq: item_q.note_frequency,
                                           dur:  item_q.note_duration};
    end
    if (note_start) begin
      rd_q <= note_mem[play_index_q];
    end
  end

  // Item capture and the three bit-serial dividers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    case (state_q)
      S_READ: begin
        psc_num_q <= DIV_W'(mts_pkg::TONE_DIVIDEND);
        psc_rem_q <= '0;
        psc_quo_q <= '0;
        cmp_num_q <= DIV_W'(item_q.adc_sample) * DIV_W'(mts_pkg::VOLUME_SCALE);
        cmp_rem_q <= '0;
        cmp_quo_q <= '0;
        mod_num_q <= DIV_W'(play_index_q) + DIV_W'(1);
        mod_rem_q <= '0;
      end
      S_DIV: begin
        psc_num_q <= psc_num_q << 1;
        psc_rem_q <= psc_rem_d;
        psc_quo_q <= {psc_quo_q[PSC_W-2:0], psc_ge};
        cmp_num_q <= cmp_num_q << 1;
        cmp_rem_q <= cmp_rem_d;
        cmp_quo_q <= {cmp_quo_q[CMP_W-2:0], cmp_ge};
        mod_num_q <= mod_num_q << 1;
        mod_rem_q <= mod_rem_d;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, playback state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      play_index_q <= '0;
      countdown_q  <= '0;
      in_gap_q     <= 1'b0;
      playing_q    <= 1'b0;
      len_q        <= mts_pkg::LEN_W'(1);
      step_q       <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      res_q        <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= res_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_EXEC;
          end
        end

        S_EXEC: begin
          res_q   <= exec_res;
          // a tick at the end of the gap goes on to fetch the note
          state_q <= note_start ? S_READ : S_DONE;
          case (item_q.op)
            mts_pkg::OP_START: begin
              play_index_q <= '0;
              countdown_q  <= '0;
              in_gap_q     <= 1'b0;
              playing_q    <= 1'b1;
            end
            mts_pkg::OP_TICK: begin
              if (!playing_q) begin
                // ticks before the first start are ignored
              end else if (countdown_q != '0) begin
                countdown_q <= countdown_q - DUR_W'(1);
              end else if (!in_gap_q) begin
                // open the silent gap between notes
                in_gap_q    <= 1'b1;
                countdown_q <= DUR_W'(mts_pkg::GAP_TICKS);
              end
            end
            default: begin
              // note writes and unknown codes leave playback alone
            end
          endcase
        end

        S_READ: begin
          countdown_q <= rd_q.dur;
          in_gap_q    <= 1'b0;
          step_q      <= '0;
          state_q     <= S_DIV;
        end

        S_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_W - 1)) begin
            state_q <= S_FIN;
          end
        end

        S_FIN: begin
          play_index_q <= AW'(mod_rem_q);
          res_q        <= fin_res;
          state_q      <= S_DONE;
        end

        S_DONE: begin
          // hold the result until the output register is free
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker: port-level assertions for the melody tone sequencer
// Watches beats on the ports and checks output stability, beat accounting and result consistency.
// ----------------------------------------------------------------------------
module mts_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input mts_pkg::mts_out_t         out_data_o
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending_q;
  logic [1:0] pending_d;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_acc   = out_valid_o && out_ready_i;
  assign pending_d = pending_q + {1'b0, in_acc} - {1'b0, out_acc};

  // Count beats accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != 2'd0) && (pending_q != 2'd3))
    else $error("output beat without a matching input beat");

  a_flags_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.compare_write || out_data_o.compare_value == '0)
                    && (out_data_o.prescaler_write || out_data_o.prescaler == '0))
    else $error("value present without its write flag");

  a_note_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.prescaler_write |->
      out_data_o.compare_write
      && (out_data_o.compare_value <= mts_pkg::CMP_MAX))
    else $error("note start with bad compare value");

endmodule

bind melody_tone_sequencer_core mts_checker u_mts_checker (.*);

FILE: test/melody_tone_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for melody_tone_sequencer_core
// Drives note writes, start commands and ticks through the input channel and
// compares every output beat with a cycle-free prediction of the sequencer.
// Random idling on both channels. The melody length changes between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any handshake before the run is declared hung
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned BEAT_TARGET  = 750;
  localparam int unsigned PHASE_BEATS  = 70;

  // The op field has one spare encoding; the core must ignore it
  localparam logic [mts_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // Outcomes that can be read straight off the behaviour
  localparam mts_pkg::mts_out_t QUIET      = '0;
  localparam mts_pkg::mts_out_t GAP_OPEN   = '{6'd0, 1'b1, 16'd0, 1'b0, 6'd0};
  // Full-scale sample gives compare 50; 1 Hz gives 45e6/1024 - 1 = 43944
  localparam mts_pkg::mts_out_t FIRST_NOTE = '{6'd50, 1'b1, 16'd43944, 1'b1, 6'd0};

  // Length settings walked first: zero, the table size, the register maximum,
  // the reset value, a short loop and one just above the table size
  localparam logic [mts_pkg::LEN_W-1:0] LENGTH_PLAN [6] =
    '{7'd0, 7'd64, 7'd127, 7'd1, 7'd3, 7'd65};

  typedef struct packed {
    mts_pkg::mts_in_t  beat;
    logic [4:0]        reps;
    mts_pkg::mts_out_t want;
  } script_row_t;

  // Opening script, run at the reset length of one note:
  // ignored tick and spare op before start, one note written, start,
  // opening gap, the whole gap counted down, then the note itself.
  localparam script_row_t SCRIPT [7] = '{
    '{'{mts_pkg::OP_TICK,  6'h3F, 16'hFFFF, 16'hFFFF, 12'hFFF}, 5'd1, QUIET},
    '{'{OP_UNUSED,         6'h3F, 16'hFFFF, 16'hFFFF, 12'hFFF}, 5'd1, QUIET},
    '{'{mts_pkg::OP_WRITE, 6'd0,  16'd1,    16'd0,    12'd0},   5'd1, QUIET},
    '{'{mts_pkg::OP_START, 6'd0,  16'd0,    16'd0,    12'd0},   5'd1, QUIET},
    '{'{mts_pkg::OP_TICK,  6'd0,  16'd0,    16'd0,    12'd0},   5'd1, GAP_OPEN},
    '{'{mts_pkg::OP_TICK,  6'h2A, 16'h5555, 16'hAAAA, 12'h555},
      5'(mts_pkg::GAP_TICKS), QUIET},
    '{'{mts_pkg::OP_TICK,  6'd0,  16'd0,    16'd0,    12'hFFF}, 5'd1, FIRST_NOTE}
  };

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  mts_pkg::mts_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  mts_pkg::mts_out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [mts_pkg::LEN_W-1:0] cfg_data = '0;

  // Predicted sequencer state
  logic [mts_pkg::FREQ_W-1:0] melody_freq [mts_pkg::DEF_MAX_NOTES];
  logic [mts_pkg::DUR_W-1:0]  melody_dur  [mts_pkg::DEF_MAX_NOTES];
  bit                         slot_loaded [mts_pkg::DEF_MAX_NOTES];
  logic [mts_pkg::SLOT_W-1:0] next_slot    = '0;
  logic [mts_pkg::DUR_W-1:0]  ticks_left   = '0;
  bit                         resting_gap  = 1'b0;
  bit                         running      = 1'b0;
  logic [mts_pkg::LEN_W-1:0]  length_reg   = 7'd1;

  mts_pkg::mts_out_t pending_updates [$];
  bit          steady = 1'b0;
  int unsigned beats_sent, lengths_tried, sounded_notes, rest_notes, gaps_opened;
  int unsigned faults, quiet_cycles;

  melody_tone_sequencer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the predicted state by one accepted beat and return the update
  // the core must emit for it.
  function automatic mts_pkg::mts_out_t advance_melody(input mts_pkg::mts_in_t b);
    mts_pkg::mts_out_t upd;
    int unsigned       span;
    int unsigned       quot;
    upd = '0;
    case (b.op)
      mts_pkg::OP_WRITE: begin
        melody_freq[b.note_slot] = b.note_frequency;
        melody_dur[b.note_slot]  = b.note_duration;
        slot_loaded[b.note_slot] = 1'b1;
      end
      mts_pkg::OP_START: begin
        next_slot   = '0;
        ticks_left  = '0;
        resting_gap = 1'b0;
        running     = 1'b1;
      end
      mts_pkg::OP_TICK: begin
        if (running) begin
          if (ticks_left != 0) begin
            ticks_left = ticks_left - 1'b1;
          end else if (resting_gap) begin
            // gap over: sound (or rest on) the note at the play position
            resting_gap       = 1'b0;
            upd.compare_write = 1'b1;
            if (melody_freq[next_slot] == 0) begin
              rest_notes++;
            end else begin
              upd.compare_value   = mts_pkg::CMP_W'((32'(b.adc_sample) * mts_pkg::VOLUME_SCALE)
                                                    / mts_pkg::ADC_FULL);
              quot = mts_pkg::CLOCK_HZ
                     / (32'(melody_freq[next_slot]) * mts_pkg::RELOAD_PLUS_ONE);
              upd.prescaler       = (quot == 0) ? '0 : mts_pkg::PSC_W'(quot - 1);
              upd.prescaler_write = 1'b1;
              sounded_notes++;
            end
            ticks_left = melody_dur[next_slot];
            // length zero plays as one, oversize as the full table
            span = (length_reg == 0) ? 1 : int'(length_reg);
            if (span > mts_pkg::DEF_MAX_NOTES) span = mts_pkg::DEF_MAX_NOTES;
            next_slot = mts_pkg::SLOT_W'((32'(next_slot) + 1) % span);
          end else begin
            resting_gap       = 1'b1;
            ticks_left        = mts_pkg::DUR_W'(mts_pkg::GAP_TICKS);
            upd.compare_write = 1'b1;
            gaps_opened++;
          end
        end
      end
      default: ;
    endcase
    upd.current_index = next_slot;
    return upd;
  endfunction

  // Mostly no pause, some short ones, a few long; none at all in steady phases
  function automatic int unsigned pause_len();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (steady || roll < 11) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    if (roll < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random payload for the given op, biased towards the field extremes
  function automatic mts_pkg::mts_in_t roll_beat(input logic [mts_pkg::OP_W-1:0] op);
    mts_pkg::mts_in_t b;
    b.op        = op;
    b.note_slot = mts_pkg::SLOT_W'($urandom_range(0, mts_pkg::DEF_MAX_NOTES - 1));
    case ($urandom_range(0, 7))
      0:       b.note_frequency = '0;
      1:       b.note_frequency = 16'd1;
      2:       b.note_frequency = 16'hFFFF;
      3:       b.note_frequency = mts_pkg::FREQ_W'($urandom_range(2, 100));
      default: b.note_frequency = mts_pkg::FREQ_W'($urandom);
    endcase
    // keep durations short so notes roll over often; the odd one runs long
    case ($urandom_range(0, 39))
      0:          b.note_duration = 16'hFFFF;
      1:          b.note_duration = mts_pkg::DUR_W'($urandom);
      2, 3, 4, 5: b.note_duration = '0;
      default:    b.note_duration = mts_pkg::DUR_W'($urandom_range(0, 3));
    endcase
    case ($urandom_range(0, 5))
      0:       b.adc_sample = '0;
      1:       b.adc_sample = 12'hFFF;
      default: b.adc_sample = mts_pkg::SAMPLE_W'($urandom);
    endcase
    return b;
  endfunction

  // Offer one beat, hold it until taken, record the expected update, then
  // maybe drop valid for a while.
  task automatic push_beat(input mts_pkg::mts_in_t beat, input bit typed,
                           input mts_pkg::mts_out_t want);
    mts_pkg::mts_out_t forecast;
    int unsigned       hold;
    in_data  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    forecast = advance_melody(beat);
    pending_updates.push_back(typed ? want : forecast);
    if (beat.op != OP_UNUSED) beats_sent++;
    hold = pause_len();
    if (hold != 0) begin
      in_valid <= 1'b0;
      repeat (hold) @(posedge clk);
    end
  endtask

  // Stop offering beats and wait until every outstanding update has arrived
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned               phase;
    int unsigned               roll;
    logic [mts_pkg::LEN_W-1:0] len_pick;
    mts_pkg::mts_in_t          b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening script at the reset length
    foreach (SCRIPT[i]) begin
      repeat (SCRIPT[i].reps) push_beat(SCRIPT[i].beat, 1'b1, SCRIPT[i].want);
    end

    // Random phases: each one drains, sets a new length and plays on
    for (phase = 0; beats_sent < BEAT_TARGET; phase++) begin
      settle();
      if (phase < 6) len_pick = LENGTH_PLAN[phase];
      else if ($urandom_range(0, 3) == 0) len_pick = mts_pkg::LEN_W'($urandom_range(1, 127));
      else len_pick = mts_pkg::LEN_W'($urandom_range(1, 12));
      cfg_data  <= len_pick;
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid  <= 1'b0;
      length_reg  = len_pick;
      lengths_tried++;
      steady = (phase % 4 == 3);

      // Half the phases carry on playing across the length change
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        push_beat(roll_beat(mts_pkg::OP_START), 1'b0, QUIET);
      end

      repeat (PHASE_BEATS) begin
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
          // fill the slot about to be played if it was never written
          if (running && ticks_left == 0 && resting_gap && !slot_loaded[next_slot]) begin
            b = roll_beat(mts_pkg::OP_WRITE);
            b.note_slot = next_slot;
            push_beat(b, 1'b0, QUIET);
          end
          push_beat(roll_beat(mts_pkg::OP_TICK), 1'b0, QUIET);
        end else if (roll < 93) begin
          push_beat(roll_beat(mts_pkg::OP_WRITE), 1'b0, QUIET);
        end else if (roll < 96) begin
          push_beat(roll_beat(mts_pkg::OP_START), 1'b0, QUIET);
        end else begin
          push_beat(roll_beat(OP_UNUSED), 1'b0, QUIET);
        end
      end
    end

    settle();
    // let any stray beat show up before closing
    repeat (40) @(posedge clk);
    $display("Run covered %0d beats over %0d length settings,", beats_sent, lengths_tried);
    $display("with %0d notes sounded, %0d rests and %0d gaps opened.",
             sounded_notes, rest_notes, gaps_opened);
    if (faults == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d faulty output beats", faults);
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Output side: stall at random, then compare each taken beat field by field
  initial begin : sink
    int unsigned       stall;
    mts_pkg::mts_out_t want;
    mts_pkg::mts_out_t got;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = pause_len();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      if (pending_updates.size() == 0) begin
        if (faults < REPORT_LIMIT)
          $display("%0t: unexpected output beat cmp=%0d/%0b psc=%0d/%0b idx=%0d", $realtime,
                   got.compare_value, got.compare_write, got.prescaler,
                   got.prescaler_write, got.current_index);
        faults++;
      end else begin
        want = pending_updates.pop_front();
        if (got.compare_value   !== want.compare_value   ||
            got.compare_write   !== want.compare_write   ||
            got.prescaler       !== want.prescaler       ||
            got.prescaler_write !== want.prescaler_write ||
            got.current_index   !== want.current_index) begin
          if (faults < REPORT_LIMIT)
            $display("%0t: want cmp=%0d/%0b psc=%0d/%0b idx=%0d, got %0d/%0b %0d/%0b %0d",
                     $realtime, want.compare_value, want.compare_write, want.prescaler,
                     want.prescaler_write, want.current_index, got.compare_value,
                     got.compare_write, got.prescaler, got.prescaler_write,
                     got.current_index);
          faults++;
        end
      end
    end
  end

  // Watchdog: any handshake on any channel resets the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timed out after %0d cycles without a beat", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
src/mts_pkg.sv
src/melody_tone_sequencer_core.sv
src/mts_checker.sv
test/melody_tone_sequencer_core_tb.sv
